// ----- rtl/core/tet_pkg.sv -----
// Package for the tempo envelope table: sizes, command and status codes,
// and the cell-to-cell structs. No dependencies.
`timescale 1ns / 1ps
package tet_pkg;
	localparam int MAX_POINTS_DEF = 16;
	localparam int TICK_W = 32;
	localparam int TEMPO_W = 24;
	localparam int HELD_W = 5;
	localparam int STATUS_W = 3;
	localparam int INDEX_W = 4;
	localparam int CMD_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE_IDX = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_REMOVE_MATCH = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK = 3'd0,
		ST_FULL = 3'd1,
		ST_EMPTY = 3'd2,
		ST_INDEX = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [TICK_W-1:0] tick;
		logic [TEMPO_W-1:0] tempo;
	} point_t;

	// Per-cell control broadcast from the sequencer.
	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_WRITE = 2'd1,
		OP_SHIFT_UP = 2'd2,
		OP_SHIFT_DOWN = 2'd3
	} cell_op_t;
endpackage

// ----- rtl/core/tet_cell.sv -----
// One table cell: holds a point and takes a new one from the command,
// its lower neighbor or its upper neighbor. Depends on tet_pkg.
`timescale 1ns / 1ps
module tet_cell (
	input  logic             clk,
	input  tet_pkg::cell_op_t op,
	input  tet_pkg::point_t   wr_pt,
	input  tet_pkg::point_t   lo_pt,
	input  tet_pkg::point_t   hi_pt,
	output tet_pkg::point_t   pt_q
);
	import tet_pkg::*;

	always_ff @(posedge clk) begin
		case (op)
			OP_WRITE: pt_q <= wr_pt;
			OP_SHIFT_UP: pt_q <= lo_pt;
			OP_SHIFT_DOWN: pt_q <= hi_pt;
			default: pt_q <= pt_q;
		endcase
	end
endmodule

// ----- rtl/core/tet_div.sv -----
// Restoring divider, one quotient bit a cycle, 56-bit dividend by
// 32-bit divisor. Depends on tet_pkg.
`timescale 1ns / 1ps
module tet_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tet_pkg::TICK_W+tet_pkg::TEMPO_W-1:0] dividend,
	input  logic [tet_pkg::TICK_W-1:0]  divisor,
	output logic                        busy,
	output logic [tet_pkg::TICK_W+tet_pkg::TEMPO_W-1:0] quotient
);
	import tet_pkg::*;
	localparam int NW = TICK_W + TEMPO_W;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [TICK_W-1:0] den_q;
	logic [TICK_W:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic [TICK_W:0] trial;
	logic [TICK_W:0] rsh;

	assign rsh = {rem_q[TICK_W-1:0], num_q[NW-1]};
	assign trial = rsh - {1'b0, den_q};
	assign quotient = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy <= 1'b1;
			cnt_q <= CW'(NW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy) begin
			if (!trial[TICK_W]) begin
				rem_q <= trial;
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rsh;
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

// ----- rtl/core/tempo_envelope_table_top.sv -----
// Tempo envelope table top: sequencer over a row of point cells plus a
// serial divider. Depends on tet_pkg, tet_cell, tet_div.
//
// Usage:
//   Input channel (valid/ready) carries cmd, point_tick, point_tempo,
//   entry_index. Output channel (out_valid/out_ready) carries tempo_out,
//   points_held, status. One result per input transfer.
//   One command at a time. After the input transfer the scan walks the table
//   up to the point count, then the apply state acts on the command. An
//   interpolating query stops its scan at the bracketing entry and then runs
//   the bit-serial divider for its 56 quotient bits before out_valid rises.
//   in_ready returns in the cycle after the result transfer.
//   Table contents move through the cell row: insert shifts cells up or
//   overwrites an equal tick, removes shift cells down, all in the same cycle.
//   Reset clears the point count and control; cell contents are not
//   cleared and are only read below the count.
//   While the receiver stalls, the result is held and in_ready stays low.
`timescale 1ns / 1ps
module tempo_envelope_table_top #(
	parameter int MAX_POINTS = tet_pkg::MAX_POINTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tet_pkg::CMD_W-1:0]    cmd,
	input  logic [tet_pkg::TICK_W-1:0]   point_tick,
	input  logic [tet_pkg::TEMPO_W-1:0]  point_tempo,
	input  logic [tet_pkg::INDEX_W-1:0]  entry_index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tet_pkg::TEMPO_W-1:0]  tempo_out,
	output logic [$clog2(MAX_POINTS+1)-1:0] points_held,
	output logic [tet_pkg::STATUS_W-1:0] status
);
	import tet_pkg::*;
	localparam int CNTW = $clog2(MAX_POINTS + 1);
	localparam int IW = $clog2(MAX_POINTS);
	localparam int NW = TICK_W + TEMPO_W;

	state_t state_q, state_d;
	cmd_t cmd_q;
	point_t in_pt_q;
	logic [INDEX_W-1:0] idx_in_q;
	logic [CNTW-1:0] cnt_q;
	logic [CNTW-1:0] scan_q;
	logic found_q;
	logic [TEMPO_W-1:0] res_tempo_q;
	status_t res_status_q;
	status_t apply_st;
	point_t prev_q;
	logic neg_q;
	logic [TEMPO_W-1:0] base_q;

	point_t cells [MAX_POINTS];
	cell_op_t ops [MAX_POINTS];
	point_t cur;
	logic [IW-1:0] scan_i;
	logic [IW-1:0] pos_i;

	logic div_start, div_busy;
	logic [NW-1:0] div_num, div_quo;
	logic [TICK_W-1:0] div_den;

	// scan position selects a cell; used by the walk and by S_APPLY
	assign scan_i = scan_q[IW-1:0];
	assign cur = cells[scan_i];

	for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
		point_t lo, hi;
		if (g == 0) begin : g_lo0
			assign lo = in_pt_q;
		end else begin : g_lo
			assign lo = cells[g-1];
		end
		if (g == MAX_POINTS - 1) begin : g_hiN
			assign hi = cells[g];
		end else begin : g_hi
			assign hi = cells[g+1];
		end
		tet_cell u_cell (
			.clk  (clk),
			.op   (ops[g]),
			.wr_pt(in_pt_q),
			.lo_pt(lo),
			.hi_pt(hi),
			.pt_q (cells[g])
		);
	end

	tet_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_num),
		.divisor (div_den),
		.busy    (div_busy),
		.quotient(div_quo)
	);

	// Scan: scan_q is the target position and found_q flags a hit when S_APPLY starts
	logic [TEMPO_W-1:0] dmag;
	logic [TICK_W-1:0] off;
	assign dmag = (cur.tempo < prev_q.tempo) ? (prev_q.tempo - cur.tempo)
		: (cur.tempo - prev_q.tempo);
	assign off = in_pt_q.tick - prev_q.tick;

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		div_num = NW'(off) * NW'(dmag);
		div_den = cur.tick - prev_q.tick;
		pos_i = scan_i;
		apply_st = ST_OK;
		for (int i = 0; i < MAX_POINTS; i++) ops[i] = OP_HOLD;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_SCAN;
			S_SCAN: begin
				if (scan_q >= cnt_q) state_d = S_APPLY;
				else begin
					case (cmd_q)
						CMD_INSERT: if (cur.tick >= in_pt_q.tick) state_d = S_APPLY;
						CMD_REMOVE_MATCH: if (cur == in_pt_q) state_d = S_APPLY;
						CMD_QUERY: if (scan_q != '0 && in_pt_q.tick < cur.tick &&
							in_pt_q.tick >= prev_q.tick) state_d = S_APPLY;
						default: state_d = S_APPLY;
					endcase
				end
			end
			S_APPLY: begin
				state_d = S_DONE;
				case (cmd_q)
					CMD_INSERT: begin
						if (scan_q < cnt_q && cur.tick == in_pt_q.tick) begin
							ops[pos_i] = OP_WRITE;
						end else if (cnt_q < CNTW'(MAX_POINTS)) begin
							for (int i = 0; i < MAX_POINTS; i++) begin
								if (CNTW'(i) > scan_q && CNTW'(i) <= cnt_q) ops[i] = OP_SHIFT_UP;
							end
							ops[pos_i] = OP_WRITE;
						end else begin
							apply_st = ST_FULL;
						end
					end
					CMD_REMOVE_IDX: begin
						if (CNTW'(idx_in_q) < cnt_q) begin
							for (int i = 0; i < MAX_POINTS; i++) begin
								if (CNTW'(i) >= CNTW'(idx_in_q) && CNTW'(i + 1) < cnt_q)
									ops[i] = OP_SHIFT_DOWN;
							end
						end else begin
							apply_st = ST_INDEX;
						end
					end
					CMD_REMOVE_MATCH: begin
						if (scan_q < cnt_q) begin
							for (int i = 0; i < MAX_POINTS; i++) begin
								if (CNTW'(i) >= scan_q && CNTW'(i + 1) < cnt_q)
									ops[i] = OP_SHIFT_DOWN;
							end
						end else begin
							apply_st = ST_NOTFOUND;
						end
					end
					default: begin
						if (cnt_q == '0) begin
							apply_st = ST_EMPTY;
						end else if (scan_q < cnt_q) begin
							div_start = 1'b1;
							state_d = S_DIV;
						end
					end
				endcase
			end
			S_DIV: if (!div_busy) state_d = S_DONE;
			default: if (out_ready) state_d = S_IDLE;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign tempo_out = res_tempo_q;
	assign points_held = cnt_q;
	assign status = res_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_APPLY) begin
				case (cmd_q)
					CMD_INSERT: if (!(scan_q < cnt_q && cur.tick == in_pt_q.tick) &&
						cnt_q < CNTW'(MAX_POINTS)) cnt_q <= cnt_q + 1'b1;
					CMD_REMOVE_IDX: if (CNTW'(idx_in_q) < cnt_q) cnt_q <= cnt_q - 1'b1;
					CMD_REMOVE_MATCH: if (scan_q < cnt_q) cnt_q <= cnt_q - 1'b1;
					default: cnt_q <= cnt_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= cmd_t'(cmd);
				in_pt_q <= '{tick: point_tick, tempo: point_tempo};
				idx_in_q <= entry_index;
				scan_q <= '0;
				found_q <= 1'b0;
			end
			S_SCAN: if (state_d == S_SCAN) begin
				prev_q <= cur;
				scan_q <= scan_q + 1'b1;
			end else begin
				found_q <= (scan_q < cnt_q);
			end
			S_APPLY: begin
				res_status_q <= apply_st;
				res_tempo_q <= (cmd_q == CMD_QUERY && cnt_q != '0 && scan_q >= cnt_q) ?
					prev_q.tempo : '0;
				neg_q <= cur.tempo < prev_q.tempo;
				base_q <= prev_q.tempo;
			end
			S_DIV: if (!div_busy && found_q)
				res_tempo_q <= neg_q ? base_q - div_quo[TEMPO_W-1:0]
					: base_q + div_quo[TEMPO_W-1:0];
			default: ;
		endcase
	end
endmodule

// ----- rtl/core/tet_checker.sv -----
// Port-level checks for tempo_envelope_table_top, bound to the top.
// Depends on tet_pkg.
`timescale 1ns / 1ps
module tet_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [tet_pkg::TEMPO_W-1:0] tempo_out,
	input logic [tet_pkg::STATUS_W-1:0] status
);
	import tet_pkg::*;
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after transfer");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tempo_out) && $stable(status))
		else $error("result changed while stalled");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> tempo_out == '0)
		else $error("nonzero tempo on failure");
	a_ret: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready) else $error("no return to idle");
endmodule

bind tempo_envelope_table_top tet_checker u_tet_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .tempo_out(tempo_out),
	.status(status)
);
